FILE: hdl/kli_pkg.sv
// Shared constants, types and codes for the keyframe linear interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none
package kli_pkg;

    localparam int MAX_KEYS   = 8;
    localparam int FRAME_BITS = 10;
    localparam int VAL_W      = 16;
    localparam int NVAL       = 7;
    localparam int FRAC_BITS  = 12;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int LEFT_W     = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
    localparam int STEP_W     = $clog2(FRAC_BITS);
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(3);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_EXACT    = 2'd0,
        KIND_BLEND    = 2'd1,
        KIND_FALLBACK = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef logic [NVAL-1:0][VAL_W-1:0] vals_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        vals_t                 vals;
    } key_t;

    // search request travelling down the cell chain
    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] q;
        logic [LEFT_W-1:0]     left;
        logic                  found;
        kind_t                 kind;
        logic [FRAME_BITS-1:0] fa;
        logic [FRAME_BITS-1:0] fb;
        vals_t                 va;
        vals_t                 vb;
    } token_t;

endpackage
`default_nettype wire

FILE: hdl/keyframe_linear_interpolator.sv
// Keyframe linear interpolator top level: register, request intake, cell chain.
// Depends on kli_pkg, kli_cell and kli_blend.
//
// Usage:
//   s_ channel takes one request per handshake. opcode write stores a keyframe
//   in slot and returns nothing; opcode query returns one result on m_.
//   cfg_valid/cfg_keyframe_count sets the number of keys in use; cfg_ready
//   is always high. Write it only while no query is in flight.
//   A query walks the eight-cell chain, then the result stage: exact and
//   fallback answers go straight to the output register, blended ones
//   first pass the serial fraction divider and the blend. One query is in
//   flight at a time; s_ready returns as soon as the result sits in the
//   output register, even if m_ready is low, so a new query is never taken
//   before the last result has been loaded.
//   Writes are taken one per cycle while no query is in flight.
//   A stalled receiver holds the result in place; the next query then waits
//   in the result stage until the register frees.
//   Reset (aresetn low, synchronous) clears all control and sets the key
//   count to 3; keyframe contents are undefined until written.
`default_nettype none
module keyframe_linear_interpolator
    import kli_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [COUNT_W-1:0]      cfg_keyframe_count,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_opcode,
    input  wire logic [SLOT_W-1:0]       s_slot,
    input  wire logic [FRAME_BITS-1:0]   s_key_frame,
    input  wire logic signed [VAL_W-1:0] s_key_pos_x,
    input  wire logic signed [VAL_W-1:0] s_key_pos_y,
    input  wire logic signed [VAL_W-1:0] s_key_pos_z,
    input  wire logic signed [VAL_W-1:0] s_key_angle,
    input  wire logic signed [VAL_W-1:0] s_key_scale_x,
    input  wire logic signed [VAL_W-1:0] s_key_scale_y,
    input  wire logic signed [VAL_W-1:0] s_key_scale_z,
    input  wire logic [FRAME_BITS-1:0]   s_query_frame,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [FRAME_BITS-1:0]        m_out_frame,
    output logic signed [VAL_W-1:0]      m_out_pos_x,
    output logic signed [VAL_W-1:0]      m_out_pos_y,
    output logic signed [VAL_W-1:0]      m_out_pos_z,
    output logic signed [VAL_W-1:0]      m_out_angle,
    output logic signed [VAL_W-1:0]      m_out_scale_x,
    output logic signed [VAL_W-1:0]      m_out_scale_y,
    output logic signed [VAL_W-1:0]      m_out_scale_z,
    output logic [1:0]                   m_match_kind
);

    logic [COUNT_W-1:0]    count_reg;
    logic                  busy_reg;
    logic                  s_acc;
    logic                  is_query;
    logic [LEFT_W-1:0]     left0;
    logic                  blend_done;
    key_t                  wr_key;
    key_t                  keys [MAX_KEYS+1];
    token_t                tok [MAX_KEYS+1];
    vals_t                 out_vals;
    kind_t                 out_kind;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg;
    assign s_acc     = s_valid && s_ready;
    assign is_query  = (s_opcode == OP_QUERY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
            busy_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_keyframe_count;
            end
            if (s_acc && is_query) begin
                busy_reg <= 1'b1;
            end else if (blend_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // slots searched before the fallback key, count clamped to 2..MAX_KEYS
    always_comb begin
        if (count_reg < COUNT_W'(2)) begin
            left0 = LEFT_W'(1);
        end else if (32'(count_reg) > MAX_KEYS) begin
            left0 = LEFT_W'(MAX_KEYS - 1);
        end else begin
            left0 = LEFT_W'(count_reg - COUNT_W'(1));
        end
    end

    always_comb begin
        wr_key.frame   = s_key_frame;
        wr_key.vals[0] = s_key_pos_x;
        wr_key.vals[1] = s_key_pos_y;
        wr_key.vals[2] = s_key_pos_z;
        wr_key.vals[3] = s_key_angle;
        wr_key.vals[4] = s_key_scale_x;
        wr_key.vals[5] = s_key_scale_y;
        wr_key.vals[6] = s_key_scale_z;
    end

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = s_acc && is_query;
        tok[0].q     = s_query_frame;
        tok[0].left  = left0;
        tok[0].kind  = KIND_FALLBACK;
    end

    assign keys[MAX_KEYS] = '0;

    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
        kli_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (s_acc && !is_query && (32'(s_slot) == i)),
            .wr_key  (wr_key),
            .nb_key  (keys[i+1]),
            .own_key (keys[i]),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    kli_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok       (tok[MAX_KEYS]),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .out_frame (m_out_frame),
        .out_vals  (out_vals),
        .out_kind  (out_kind),
        .done      (blend_done)
    );

    assign m_out_pos_x   = out_vals[0];
    assign m_out_pos_y   = out_vals[1];
    assign m_out_pos_z   = out_vals[2];
    assign m_out_angle   = out_vals[3];
    assign m_out_scale_x = out_vals[4];
    assign m_out_scale_y = out_vals[5];
    assign m_out_scale_z = out_vals[6];
    assign m_match_kind  = out_kind;

endmodule
`default_nettype wire

FILE: hdl/kli_cell.sv
// One keyframe cell: stores a key and checks a passing search request against it
// and its right neighbor, or takes it as the fallback key. Depends on kli_pkg.
`default_nettype none
module kli_cell
    import kli_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_en,
    input  wire key_t   wr_key,
    input  wire key_t   nb_key,
    output key_t        own_key,
    input  wire token_t tok_in,
    output token_t      tok_out
);

    key_t   key_reg;
    token_t tok_reg;
    token_t tok_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg <= wr_key;
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found) begin
            if (tok_in.left == '0) begin
                tok_next.found = 1'b1;
                tok_next.kind  = KIND_FALLBACK;
                tok_next.va    = key_reg.vals;
            end else begin
                tok_next.left = tok_in.left - LEFT_W'(1);
                if (key_reg.frame == tok_in.q) begin
                    tok_next.found = 1'b1;
                    tok_next.kind  = KIND_EXACT;
                    tok_next.va    = key_reg.vals;
                end else if (key_reg.frame < tok_in.q && nb_key.frame > tok_in.q) begin
                    tok_next.found = 1'b1;
                    tok_next.kind  = KIND_BLEND;
                    tok_next.fa    = key_reg.frame;
                    tok_next.fb    = nb_key.frame;
                    tok_next.va    = key_reg.vals;
                    tok_next.vb    = nb_key.vals;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign own_key = key_reg;
    assign tok_out = tok_reg;

endmodule
`default_nettype wire

FILE: hdl/kli_blend.sv
// Result stage: serial fraction divider, per-value blend and output register.
// Depends on kli_pkg; fed by the last cell of the chain.
`default_nettype none
module kli_blend
    import kli_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire token_t                tok,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic [FRAME_BITS-1:0]      out_frame,
    output vals_t                      out_vals,
    output kind_t                      out_kind,
    output logic                       done
);

    state_t state_reg, state_next;

    logic [FRAME_BITS-1:0]            q_reg;
    kind_t                            kind_reg;
    vals_t                            va_reg, vb_reg, res_reg;
    logic [FRAME_BITS:0]              rem_reg;
    logic [FRAME_BITS-1:0]            den_reg;
    logic [FRAC_BITS-1:0]             quo_reg;
    logic [STEP_W-1:0]                step_reg;
    logic signed [PROD_W-1:0]         prod_reg [NVAL];
    logic                             m_valid_reg;
    logic [FRAME_BITS-1:0]            m_frame_reg;
    vals_t                            m_vals_reg;
    kind_t                            m_kind_reg;

    logic [FRAME_BITS+1:0]            rem_dbl;
    logic                             load_out;

    assign rem_dbl = {rem_reg, 1'b0};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (tok.valid) begin
                    state_next = (tok.kind == KIND_BLEND) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(FRAC_BITS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
        done     = load_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                q_reg    <= tok.q;
                kind_reg <= tok.kind;
                va_reg   <= tok.va;
                vb_reg   <= tok.vb;
                res_reg  <= tok.va;
                rem_reg  <= {1'b0, tok.q - tok.fa};
                den_reg  <= tok.fb - tok.fa;
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV: begin
                // restoring step, one quotient bit per cycle
                if (rem_dbl >= {2'b00, den_reg}) begin
                    rem_reg <= (FRAME_BITS+1)'(rem_dbl - {2'b00, den_reg});
                    quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_dbl[FRAME_BITS:0];
                    quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b0};
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_MUL: begin
                for (int j = 0; j < NVAL; j++) begin
                    prod_reg[j] <= ($signed({vb_reg[j][VAL_W-1], vb_reg[j]})
                                  - $signed({va_reg[j][VAL_W-1], va_reg[j]}))
                                  * $signed({1'b0, quo_reg});
                end
            end
            ST_SUM: begin
                for (int j = 0; j < NVAL; j++) begin
                    res_reg[j] <= va_reg[j] + VAL_W'(prod_reg[j] >>> FRAC_BITS);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_frame_reg <= q_reg;
            m_vals_reg  <= res_reg;
            m_kind_reg  <= kind_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign out_frame = m_frame_reg;
    assign out_vals  = m_vals_reg;
    assign out_kind  = m_kind_reg;

endmodule
`default_nettype wire

FILE: verif/keyframe_linear_interpolator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for keyframe_linear_interpolator: key writes, frame queries, key counts.
// Needs kli_pkg and the interpolator RTL; queued requests, own blend predictor, random stalls.
module keyframe_linear_interpolator_test;
    import kli_pkg::*;

    localparam int NUM_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 141;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_W-1:0]     slot;
        logic [FRAME_BITS-1:0] key_frame;
        vals_t                 vals;
        logic [FRAME_BITS-1:0] query_frame;
    } request_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        vals_t                 vals;
        kind_t                 kind;
    } answer_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_keyframe_count = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_opcode = 1'b0;
    logic [SLOT_W-1:0]     s_slot = '0;
    logic [FRAME_BITS-1:0] s_key_frame = '0;
    logic signed [VAL_W-1:0] s_key_pos_x = '0, s_key_pos_y = '0, s_key_pos_z = '0;
    logic signed [VAL_W-1:0] s_key_angle = '0;
    logic signed [VAL_W-1:0] s_key_scale_x = '0, s_key_scale_y = '0, s_key_scale_z = '0;
    logic [FRAME_BITS-1:0] s_query_frame = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [FRAME_BITS-1:0] m_out_frame;
    logic signed [VAL_W-1:0] m_out_pos_x, m_out_pos_y, m_out_pos_z, m_out_angle;
    logic signed [VAL_W-1:0] m_out_scale_x, m_out_scale_y, m_out_scale_z;
    logic [1:0]            m_match_kind;

    keyframe_linear_interpolator uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_keyframe_count (cfg_keyframe_count),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_slot             (s_slot),
        .s_key_frame        (s_key_frame),
        .s_key_pos_x        (s_key_pos_x),
        .s_key_pos_y        (s_key_pos_y),
        .s_key_pos_z        (s_key_pos_z),
        .s_key_angle        (s_key_angle),
        .s_key_scale_x      (s_key_scale_x),
        .s_key_scale_y      (s_key_scale_y),
        .s_key_scale_z      (s_key_scale_z),
        .s_query_frame      (s_query_frame),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_frame        (m_out_frame),
        .m_out_pos_x        (m_out_pos_x),
        .m_out_pos_y        (m_out_pos_y),
        .m_out_pos_z        (m_out_pos_z),
        .m_out_angle        (m_out_angle),
        .m_out_scale_x      (m_out_scale_x),
        .m_out_scale_y      (m_out_scale_y),
        .m_out_scale_z      (m_out_scale_z),
        .m_match_kind       (m_match_kind)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    request_t presented;
    answer_t  oldest;
    vals_t    seen_vals;
    int       mismatches = 0;
    int       send_idle_pct = 9;
    int       recv_idle_pct = 60;

    // key table as the block should hold it
    logic [FRAME_BITS-1:0] stored_frame[MAX_KEYS];
    vals_t                 stored_vals[MAX_KEYS];
    logic [COUNT_W-1:0]    key_count = COUNT_RESET;

    // key frames as the request generator has queued them
    int gen_frame[MAX_KEYS];
    int gen_keys;

    string val_names[NVAL] = '{"pos_x", "pos_y", "pos_z", "angle",
                               "scale_x", "scale_y", "scale_z"};

    function automatic int keys_in_use(input int c);
        if (c < 2) return 2;
        if (c > MAX_KEYS) return MAX_KEYS;
        return c;
    endfunction

    task automatic predict_request(input request_t r);
        answer_t res;
        int      n, a, b, q, delta;
        longint  pv, diff;
        bit      done;
        if (r.op == OP_WRITE) begin
            stored_frame[r.slot] = r.key_frame;
            stored_vals[r.slot]  = r.vals;
        end else begin
            q         = r.query_frame;
            n         = keys_in_use(key_count);
            res.frame = r.query_frame;
            res.kind  = KIND_FALLBACK;
            res.vals  = stored_vals[n-1];
            done      = 1'b0;
            for (int i = 0; i + 1 < n && !done; i++) begin
                a = stored_frame[i];
                b = stored_frame[i+1];
                if (a == q) begin
                    res.kind = KIND_EXACT;
                    res.vals = stored_vals[i];
                    done     = 1'b1;
                end else if (a < q && b > q) begin
                    delta = ((q - a) << FRAC_BITS) / (b - a);
                    for (int j = 0; j < NVAL; j++) begin
                        pv   = longint'($signed(stored_vals[i][j]));
                        diff = longint'($signed(stored_vals[i+1][j])) - pv;
                        res.vals[j] = VAL_W'(pv + ((diff * longint'(delta)) >>> FRAC_BITS));
                    end
                    res.kind = KIND_BLEND;
                    done     = 1'b1;
                end
            end
            expected_answers.push_back(res);
        end
    endtask

    function automatic vals_t random_vals();
        vals_t v;
        int    pick;
        for (int j = 0; j < NVAL; j++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v[j] = 16'h7fff;
            else if (pick == 1)
                v[j] = 16'h8000;
            else
                v[j] = VAL_W'($urandom);
        end
        return v;
    endfunction

    task automatic queue_write(input int slot, input int frame, input vals_t vals);
        request_t r;
        r.op          = OP_WRITE;
        r.slot        = SLOT_W'(slot);
        r.key_frame   = FRAME_BITS'(frame);
        r.vals        = vals;
        r.query_frame = FRAME_BITS'($urandom_range(0, 1023));
        pending_requests.push_back(r);
        gen_frame[slot] = frame;
    endtask

    task automatic queue_query(input int frame);
        request_t r;
        r.op          = OP_QUERY;
        r.slot        = SLOT_W'($urandom_range(0, MAX_KEYS - 1));
        r.key_frame   = FRAME_BITS'($urandom_range(0, 1023));
        r.vals        = random_vals();
        r.query_frame = FRAME_BITS'(frame);
        pending_requests.push_back(r);
    endtask

    // query near the keys in use: on a key, between two, at or past the last, or anywhere
    task automatic queue_shaped_query();
        int pick, i, lo, hi;
        pick = $urandom_range(0, 99);
        i    = $urandom_range(0, gen_keys - 2);
        lo   = gen_frame[i];
        hi   = gen_frame[i+1];
        if (pick < 35)
            queue_query(gen_frame[$urandom_range(0, gen_keys - 1)]);
        else if (pick < 75 && hi > lo + 1)
            queue_query($urandom_range(lo + 1, hi - 1));
        else if (pick < 88)
            queue_query($urandom_range(gen_frame[gen_keys-1], 1023));
        else
            queue_query($urandom_range(0, 1023));
    endtask

    task automatic rebuild_keys();
        int f;
        f = $urandom_range(0, 60);
        for (int s = 0; s < MAX_KEYS; s++) begin
            queue_write(s, f, random_vals());
            f = f + $urandom_range(1, 150);
            if (f > 1023) f = 1023;
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_valid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_count(input logic [COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_valid          <= 1'b1;
        cfg_keyframe_count <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        key_count = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_request(presented);
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    presented = pending_requests.pop_front();
                    s_valid       <= 1'b1;
                    s_opcode      <= presented.op;
                    s_slot        <= presented.slot;
                    s_key_frame   <= presented.key_frame;
                    s_key_pos_x   <= presented.vals[0];
                    s_key_pos_y   <= presented.vals[1];
                    s_key_pos_z   <= presented.vals[2];
                    s_key_angle   <= presented.vals[3];
                    s_key_scale_x <= presented.vals[4];
                    s_key_scale_y <= presented.vals[5];
                    s_key_scale_z <= presented.vals[6];
                    s_query_frame <= presented.query_frame;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result for frame %0d with no query pending",
                                 $time, m_out_frame);
                    mismatches++;
                end else begin
                    oldest    = expected_answers.pop_front();
                    seen_vals = {m_out_scale_z, m_out_scale_y, m_out_scale_x, m_out_angle,
                                 m_out_pos_z, m_out_pos_y, m_out_pos_x};
                    check_field("frame", VAL_W'(oldest.frame), VAL_W'(m_out_frame));
                    for (int j = 0; j < NVAL; j++)
                        check_field(val_names[j], oldest.vals[j], seen_vals[j]);
                    check_field("match_kind", VAL_W'(oldest.kind), VAL_W'(m_match_kind));
                end
            end
        end
    end

    initial begin
        int phase_counts[NUM_PHASES];
        int made, pick;
        phase_counts = '{3, 15, 0, 8, 2, 5, 9, 1, 7, 4, 6};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                write_key_count(COUNT_W'(phase_counts[p]));
            end
            if (p < 4) begin
                send_idle_pct = 9;
                recv_idle_pct = 60;
            end else if (p < 8) begin
                send_idle_pct = 60;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            gen_keys = keys_in_use(phase_counts[p]);
            if (p == 0) begin
                // full-scale swing between the first two keys, then spread keys
                queue_write(0, 0, vals_t'({NVAL{16'h8000}}));
                queue_write(1, 40, vals_t'({NVAL{16'h7fff}}));
                queue_write(2, 300, random_vals());
                queue_write(3, 301, random_vals());
                queue_write(4, 500, random_vals());
                queue_write(5, 700, random_vals());
                queue_write(6, 900, random_vals());
                queue_write(7, 1023, random_vals());
                queue_query(0);
                queue_query(20);
                queue_query(40);
                queue_query(41);
                queue_query(170);
                queue_query(299);
                queue_query(300);
                queue_query(301);
                queue_query(1023);
            end
            made = 0;
            while (made < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    rebuild_keys();
                    made += MAX_KEYS;
                end else if (pick < 16) begin
                    // stray write, may leave the table out of order
                    queue_write($urandom_range(0, MAX_KEYS - 1), $urandom_range(0, 1023),
                                random_vals());
                    made++;
                end else begin
                    queue_shaped_query();
                    made++;
                end
            end
        end
        wait_idle();
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
